### hdl/stsu_pkg.sv
// Shared types, constants and helpers of the simplex tableau solver unit.
// Used by stsu_div, stsu_ctrl, stsu_dpath and simplex_tableau_solver_unit.
package stsu_pkg;

  localparam int unsigned MaxRows = 16;
  localparam int unsigned MaxCols = 16;
  localparam int unsigned Stride  = MaxCols + 1;
  localparam int unsigned Depth   = (MaxRows + 1) * (MaxCols + 1);
  localparam int unsigned AddrW   = $clog2(Depth);

  localparam logic [1:0] StatusOptimal   = 2'd0;
  localparam logic [1:0] StatusUnbounded = 2'd1;
  localparam logic [1:0] StatusLimit     = 2'd2;

  localparam logic [1:0] RegRowsUsed  = 2'd0;
  localparam logic [1:0] RegColsUsed  = 2'd1;
  localparam logic [1:0] RegIterLimit = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE, S_COL_ADDR, S_COL_EVAL, S_OPT_ADDR, S_OPT_OUT, S_LIM_ADDR, S_LIM_OUT,
    S_UNB_OUT, S_ROW_A_ADDR, S_ROW_A_EVAL, S_ROW_B_ADDR, S_ROW_B_EVAL, S_ROW_MUL,
    S_ROW_CMP, S_ROW_ADV, S_ROW_END, S_RCP_LOAD, S_RCP_START, S_RCP_WAIT, S_RCP_SET,
    S_EX_CHECK, S_EX_A_ADDR, S_EX_A_EVAL, S_EX_C_ADDR, S_EX_C_EVAL, S_EX_W_ADDR,
    S_EX_W_EVAL, S_EX_MUL, S_EX_SUB, S_EX_ABS, S_EX_START, S_EX_WAIT, S_EX_WR,
    S_EX_ADV, S_PR_CHECK, S_PR_ADDR, S_PR_EVAL, S_PR_MUL, S_PR_ABS, S_PR_WR,
    S_PR_ADV, S_PC_CHECK, S_PC_ADDR, S_PC_EVAL, S_PC_MUL, S_PC_ABS, S_PC_WR,
    S_PC_ADV, S_PIV_WR
  } state_e;

  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_e;

  typedef enum logic [2:0] {
    ADDR_IN, ADDR_M_J, ADDR_M_N, ADDR_I_PC, ADDR_I_N, ADDR_I_J, ADDR_PR_J, ADDR_PR_PC
  } addr_sel_e;

  typedef enum logic [1:0] {WD_IN, WD_DIV, WD_SCALE, WD_RCP} wd_sel_e;
  typedef enum logic [1:0] {MUL_RATIO, MUL_EXCH, MUL_SCALE} mul_sel_e;
  typedef enum logic [1:0] {MAG_DIFF, MAG_ONE, MAG_ROW, MAG_COL} mag_sel_e;

  typedef struct packed {
    logic       solve_init;
    logic       search_clr;
    cnt_op_e    i_op;
    cnt_op_e    j_op;
    addr_sel_e  addr_sel;
    logic       we;
    wd_sel_e    wd_sel;
    logic       col_upd;
    logic       row_upd;
    logic       ld_a;
    logic       ld_b;
    logic       ld_c;
    mul_sel_e   mul_sel;
    logic       mul_en;
    logic       sub_en;
    logic       mag_en;
    mag_sel_e   mag_sel;
    logic       div_start;
    logic       rcp_load;
    logic       cnt_inc;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_zero;
  } cmd_t;

  typedef struct packed {
    logic need_nx;
    logic rd_pos;
    logic found;
    logic limit_hit;
    logic i_eq_pr;
    logic j_eq_pc;
    logic i_is_m;
    logic i_is_m1;
    logic j_is_n;
    logic j_is_n1;
    logic div_done;
  } sts_t;

  function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (mag >= 64'h8000_0000) r = 32'sh8000_0000;
      else r = -$signed(mag[31:0]);
    end else begin
      if (mag >= 64'h8000_0000) r = 32'sh7FFF_FFFF;
      else r = $signed(mag[31:0]);
    end
    return r;
  endfunction

endpackage

### hdl/stsu_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, signed saturated result.
// Depends on stsu_pkg.
module stsu_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        num_i,
  input  logic [31:0]        den_i,
  input  logic               neg_i,
  output logic               done_o,
  output logic signed [31:0] res_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d, den_q, den_d;
  logic        neg_q, neg_d;
  logic [32:0] tmp;
  logic        ge;

  assign tmp = {rem_q, quo_q[63]};
  assign ge  = tmp >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = neg_i;
    end else if (busy_q) begin
      rem_d = ge ? 32'(tmp - {1'b0, den_q}) : tmp[31:0];
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign res_o  = stsu_pkg::sat_mag(quo_q, neg_q);

endmodule

### hdl/stsu_ctrl.sv
// Solve sequencer: loads entries, runs column and row search and the exchange.
// Depends on stsu_pkg; drives stsu_dpath through cmd_t and reads sts_t.
module stsu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  input  logic           out_ready_i,
  input  stsu_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output stsu_pkg::cmd_t cmd_o
);

  stsu_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  stsu_pkg::cmd_t   c;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stsu_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    c            = '0;
    c.i_op       = stsu_pkg::CNT_HOLD;
    c.j_op       = stsu_pkg::CNT_HOLD;
    c.addr_sel   = stsu_pkg::ADDR_IN;
    c.wd_sel     = stsu_pkg::WD_IN;
    c.mul_sel    = stsu_pkg::MUL_RATIO;
    c.mag_sel    = stsu_pkg::MAG_DIFF;
    c.out_status = stsu_pkg::StatusOptimal;
    state_d      = state_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      stsu_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        c.we       = in_valid_i;
        if (in_valid_i && in_last_i) begin
          c.solve_init = 1'b1;
          c.search_clr = 1'b1;
          state_d      = stsu_pkg::S_COL_ADDR;
        end
      end
      stsu_pkg::S_COL_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_M_J;
        state_d    = stsu_pkg::S_COL_EVAL;
      end
      stsu_pkg::S_COL_EVAL: begin
        c.addr_sel = stsu_pkg::ADDR_M_J;
        c.col_upd  = 1'b1;
        if (sts_i.j_is_n1) begin
          if (sts_i.need_nx) begin
            c.i_op  = stsu_pkg::CNT_CLR;
            state_d = stsu_pkg::S_ROW_A_ADDR;
          end else begin
            state_d = stsu_pkg::S_OPT_ADDR;
          end
        end else begin
          c.j_op  = stsu_pkg::CNT_INC;
          state_d = stsu_pkg::S_COL_ADDR;
        end
      end
      stsu_pkg::S_OPT_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_M_N;
        state_d    = stsu_pkg::S_OPT_OUT;
      end
      stsu_pkg::S_OPT_OUT: begin
        c.addr_sel = stsu_pkg::ADDR_M_N;
        if (out_free) begin
          c.out_load   = 1'b1;
          c.out_status = stsu_pkg::StatusOptimal;
          state_d      = stsu_pkg::S_IDLE;
        end
      end
      stsu_pkg::S_LIM_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_M_N;
        state_d    = stsu_pkg::S_LIM_OUT;
      end
      stsu_pkg::S_LIM_OUT: begin
        c.addr_sel = stsu_pkg::ADDR_M_N;
        if (out_free) begin
          c.out_load   = 1'b1;
          c.out_status = stsu_pkg::StatusLimit;
          state_d      = stsu_pkg::S_IDLE;
        end
      end
      stsu_pkg::S_UNB_OUT: begin
        if (out_free) begin
          c.out_load   = 1'b1;
          c.out_status = stsu_pkg::StatusUnbounded;
          c.out_zero   = 1'b1;
          state_d      = stsu_pkg::S_IDLE;
        end
      end
      stsu_pkg::S_ROW_A_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_I_PC;
        state_d    = stsu_pkg::S_ROW_A_EVAL;
      end
      stsu_pkg::S_ROW_A_EVAL: begin
        c.ld_a  = 1'b1;
        state_d = sts_i.rd_pos ? stsu_pkg::S_ROW_B_ADDR : stsu_pkg::S_ROW_ADV;
      end
      stsu_pkg::S_ROW_B_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_I_N;
        state_d    = stsu_pkg::S_ROW_B_EVAL;
      end
      stsu_pkg::S_ROW_B_EVAL: begin
        c.ld_b  = 1'b1;
        state_d = stsu_pkg::S_ROW_MUL;
      end
      stsu_pkg::S_ROW_MUL: begin
        c.mul_en  = 1'b1;
        c.mul_sel = stsu_pkg::MUL_RATIO;
        state_d   = stsu_pkg::S_ROW_CMP;
      end
      stsu_pkg::S_ROW_CMP: begin
        c.row_upd = 1'b1;
        state_d   = stsu_pkg::S_ROW_ADV;
      end
      stsu_pkg::S_ROW_ADV: begin
        if (sts_i.i_is_m1) begin
          state_d = stsu_pkg::S_ROW_END;
        end else begin
          c.i_op  = stsu_pkg::CNT_INC;
          state_d = stsu_pkg::S_ROW_A_ADDR;
        end
      end
      stsu_pkg::S_ROW_END: begin
        if (!sts_i.found) state_d = stsu_pkg::S_UNB_OUT;
        else if (sts_i.limit_hit) state_d = stsu_pkg::S_LIM_ADDR;
        else state_d = stsu_pkg::S_RCP_LOAD;
      end
      stsu_pkg::S_RCP_LOAD: begin
        c.mag_en  = 1'b1;
        c.mag_sel = stsu_pkg::MAG_ONE;
        state_d   = stsu_pkg::S_RCP_START;
      end
      stsu_pkg::S_RCP_START: begin
        c.div_start = 1'b1;
        state_d     = stsu_pkg::S_RCP_WAIT;
      end
      stsu_pkg::S_RCP_WAIT: begin
        if (sts_i.div_done) state_d = stsu_pkg::S_RCP_SET;
      end
      stsu_pkg::S_RCP_SET: begin
        c.rcp_load = 1'b1;
        c.i_op     = stsu_pkg::CNT_CLR;
        c.j_op     = stsu_pkg::CNT_CLR;
        state_d    = stsu_pkg::S_EX_CHECK;
      end
      stsu_pkg::S_EX_CHECK: begin
        state_d = (sts_i.i_eq_pr || sts_i.j_eq_pc) ? stsu_pkg::S_EX_ADV
                                                   : stsu_pkg::S_EX_A_ADDR;
      end
      stsu_pkg::S_EX_A_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_I_J;
        state_d    = stsu_pkg::S_EX_A_EVAL;
      end
      stsu_pkg::S_EX_A_EVAL: begin
        c.ld_a  = 1'b1;
        state_d = stsu_pkg::S_EX_C_ADDR;
      end
      stsu_pkg::S_EX_C_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_I_PC;
        state_d    = stsu_pkg::S_EX_C_EVAL;
      end
      stsu_pkg::S_EX_C_EVAL: begin
        c.ld_b  = 1'b1;
        state_d = stsu_pkg::S_EX_W_ADDR;
      end
      stsu_pkg::S_EX_W_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_PR_J;
        state_d    = stsu_pkg::S_EX_W_EVAL;
      end
      stsu_pkg::S_EX_W_EVAL: begin
        c.ld_c  = 1'b1;
        state_d = stsu_pkg::S_EX_MUL;
      end
      stsu_pkg::S_EX_MUL: begin
        c.mul_en  = 1'b1;
        c.mul_sel = stsu_pkg::MUL_EXCH;
        state_d   = stsu_pkg::S_EX_SUB;
      end
      stsu_pkg::S_EX_SUB: begin
        c.sub_en = 1'b1;
        state_d  = stsu_pkg::S_EX_ABS;
      end
      stsu_pkg::S_EX_ABS: begin
        c.mag_en  = 1'b1;
        c.mag_sel = stsu_pkg::MAG_DIFF;
        state_d   = stsu_pkg::S_EX_START;
      end
      stsu_pkg::S_EX_START: begin
        c.div_start = 1'b1;
        state_d     = stsu_pkg::S_EX_WAIT;
      end
      stsu_pkg::S_EX_WAIT: begin
        if (sts_i.div_done) state_d = stsu_pkg::S_EX_WR;
      end
      stsu_pkg::S_EX_WR: begin
        c.addr_sel = stsu_pkg::ADDR_I_J;
        c.we       = 1'b1;
        c.wd_sel   = stsu_pkg::WD_DIV;
        state_d    = stsu_pkg::S_EX_ADV;
      end
      stsu_pkg::S_EX_ADV: begin
        if (sts_i.j_is_n) begin
          c.j_op = stsu_pkg::CNT_CLR;
          if (sts_i.i_is_m) begin
            state_d = stsu_pkg::S_PR_CHECK;
          end else begin
            c.i_op  = stsu_pkg::CNT_INC;
            state_d = stsu_pkg::S_EX_CHECK;
          end
        end else begin
          c.j_op  = stsu_pkg::CNT_INC;
          state_d = stsu_pkg::S_EX_CHECK;
        end
      end
      stsu_pkg::S_PR_CHECK: begin
        state_d = sts_i.j_eq_pc ? stsu_pkg::S_PR_ADV : stsu_pkg::S_PR_ADDR;
      end
      stsu_pkg::S_PR_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_PR_J;
        state_d    = stsu_pkg::S_PR_EVAL;
      end
      stsu_pkg::S_PR_EVAL: begin
        c.ld_a  = 1'b1;
        state_d = stsu_pkg::S_PR_MUL;
      end
      stsu_pkg::S_PR_MUL: begin
        c.mul_en  = 1'b1;
        c.mul_sel = stsu_pkg::MUL_SCALE;
        state_d   = stsu_pkg::S_PR_ABS;
      end
      stsu_pkg::S_PR_ABS: begin
        c.mag_en  = 1'b1;
        c.mag_sel = stsu_pkg::MAG_ROW;
        state_d   = stsu_pkg::S_PR_WR;
      end
      stsu_pkg::S_PR_WR: begin
        c.addr_sel = stsu_pkg::ADDR_PR_J;
        c.we       = 1'b1;
        c.wd_sel   = stsu_pkg::WD_SCALE;
        state_d    = stsu_pkg::S_PR_ADV;
      end
      stsu_pkg::S_PR_ADV: begin
        if (sts_i.j_is_n) begin
          c.i_op  = stsu_pkg::CNT_CLR;
          state_d = stsu_pkg::S_PC_CHECK;
        end else begin
          c.j_op  = stsu_pkg::CNT_INC;
          state_d = stsu_pkg::S_PR_CHECK;
        end
      end
      stsu_pkg::S_PC_CHECK: begin
        state_d = sts_i.i_eq_pr ? stsu_pkg::S_PC_ADV : stsu_pkg::S_PC_ADDR;
      end
      stsu_pkg::S_PC_ADDR: begin
        c.addr_sel = stsu_pkg::ADDR_I_PC;
        state_d    = stsu_pkg::S_PC_EVAL;
      end
      stsu_pkg::S_PC_EVAL: begin
        c.ld_a  = 1'b1;
        state_d = stsu_pkg::S_PC_MUL;
      end
      stsu_pkg::S_PC_MUL: begin
        c.mul_en  = 1'b1;
        c.mul_sel = stsu_pkg::MUL_SCALE;
        state_d   = stsu_pkg::S_PC_ABS;
      end
      stsu_pkg::S_PC_ABS: begin
        c.mag_en  = 1'b1;
        c.mag_sel = stsu_pkg::MAG_COL;
        state_d   = stsu_pkg::S_PC_WR;
      end
      stsu_pkg::S_PC_WR: begin
        c.addr_sel = stsu_pkg::ADDR_I_PC;
        c.we       = 1'b1;
        c.wd_sel   = stsu_pkg::WD_SCALE;
        state_d    = stsu_pkg::S_PC_ADV;
      end
      stsu_pkg::S_PC_ADV: begin
        if (sts_i.i_is_m) begin
          state_d = stsu_pkg::S_PIV_WR;
        end else begin
          c.i_op  = stsu_pkg::CNT_INC;
          state_d = stsu_pkg::S_PC_CHECK;
        end
      end
      stsu_pkg::S_PIV_WR: begin
        c.addr_sel   = stsu_pkg::ADDR_PR_PC;
        c.we         = 1'b1;
        c.wd_sel     = stsu_pkg::WD_RCP;
        c.cnt_inc    = 1'b1;
        c.search_clr = 1'b1;
        state_d      = stsu_pkg::S_COL_ADDR;
      end
      default: state_d = stsu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (c.out_load) out_valid_d = 1'b1;
  end

  assign cmd_o       = c;
  assign out_valid_o = out_valid_q;

endmodule

### hdl/stsu_dpath.sv
// Tableau memory, configuration registers, search registers and the
// multiply, round and divide path. Depends on stsu_pkg and stsu_div.
module stsu_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stsu_pkg::cmd_t     cmd_i,
  output stsu_pkg::sts_t     sts_o,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [4:0]         in_row_i,
  input  logic [4:0]         in_column_i,
  input  logic signed [31:0] in_value_i,
  output logic [1:0]         out_status_o,
  output logic signed [31:0] out_optimum_o,
  output logic [9:0]         out_pivots_o
);

  localparam int unsigned AddrW = stsu_pkg::AddrW;

  logic signed [31:0] mem [stsu_pkg::Depth];
  logic signed [31:0] rdata_q;

  logic [4:0] rows_cfg_q, cols_cfg_q;
  logic [9:0] limit_q;
  logic [4:0] m_q, n_q, i_q, j_q, pr_q, pc_q;
  logic [9:0] cnt_q;
  logic       need_q, found_q;
  logic signed [31:0] best_q, ak_q, bk_q, a_q, b_q, c_q, rcp_q;
  logic signed [63:0] m1_q, m2_q, diff_q;
  logic [63:0]        mag_q;
  logic               neg_q;
  logic [1:0]         res_status_q;
  logic signed [31:0] res_opt_q;
  logic [9:0]         res_cnt_q;

  logic [4:0]         row_sel, col_sel, m_clamp, n_clamp;
  logic [AddrW-1:0]   addr;
  logic               in_ok, we;
  logic signed [31:0] wdata, div_res, mul_a, mul_b, mul_c, mul_d;
  logic [63:0]        scl_sum;
  logic               div_done;

  assign m_clamp = (rows_cfg_q == 5'd0) ? 5'd1 :
                   (rows_cfg_q > 5'(stsu_pkg::MaxRows)) ? 5'(stsu_pkg::MaxRows) : rows_cfg_q;
  assign n_clamp = (cols_cfg_q == 5'd0) ? 5'd1 :
                   (cols_cfg_q > 5'(stsu_pkg::MaxCols)) ? 5'(stsu_pkg::MaxCols) : cols_cfg_q;

  always_comb begin
    unique case (cmd_i.addr_sel)
      stsu_pkg::ADDR_IN:    begin row_sel = in_row_i; col_sel = in_column_i; end
      stsu_pkg::ADDR_M_J:   begin row_sel = m_q;      col_sel = j_q;         end
      stsu_pkg::ADDR_M_N:   begin row_sel = m_q;      col_sel = n_q;         end
      stsu_pkg::ADDR_I_PC:  begin row_sel = i_q;      col_sel = pc_q;        end
      stsu_pkg::ADDR_I_N:   begin row_sel = i_q;      col_sel = n_q;         end
      stsu_pkg::ADDR_I_J:   begin row_sel = i_q;      col_sel = j_q;         end
      stsu_pkg::ADDR_PR_J:  begin row_sel = pr_q;     col_sel = j_q;         end
      stsu_pkg::ADDR_PR_PC: begin row_sel = pr_q;     col_sel = pc_q;        end
      default:              begin row_sel = i_q;      col_sel = j_q;         end
    endcase
  end

  assign addr  = AddrW'(AddrW'(row_sel) * AddrW'(stsu_pkg::Stride) + AddrW'(col_sel));
  assign in_ok = (in_row_i <= 5'(stsu_pkg::MaxRows)) && (in_column_i <= 5'(stsu_pkg::MaxCols));
  assign we    = cmd_i.we && ((cmd_i.addr_sel != stsu_pkg::ADDR_IN) || in_ok);

  assign scl_sum = mag_q + 64'd32768;

  always_comb begin
    unique case (cmd_i.wd_sel)
      stsu_pkg::WD_IN:    wdata = in_value_i;
      stsu_pkg::WD_DIV:   wdata = div_res;
      stsu_pkg::WD_SCALE: wdata = stsu_pkg::sat_mag({16'd0, scl_sum[63:16]}, neg_q);
      stsu_pkg::WD_RCP:   wdata = rcp_q;
      default:            wdata = in_value_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 5'd1;
      cols_cfg_q <= 5'd1;
      limit_q    <= 10'd255;
      cnt_q      <= '0;
      need_q     <= 1'b0;
      found_q    <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      m_q        <= 5'd1;
      n_q        <= 5'd1;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          stsu_pkg::RegRowsUsed:  rows_cfg_q <= cfg_data_i[4:0];
          stsu_pkg::RegColsUsed:  cols_cfg_q <= cfg_data_i[4:0];
          stsu_pkg::RegIterLimit: limit_q    <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (cmd_i.solve_init) begin
        m_q   <= m_clamp;
        n_q   <= n_clamp;
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 10'd1;
      end
      if (cmd_i.search_clr) begin
        need_q  <= 1'b0;
        found_q <= 1'b0;
        j_q     <= '0;
      end else begin
        if (cmd_i.col_upd && rdata_q < 0 && (!need_q || rdata_q < best_q)) need_q <= 1'b1;
        if (cmd_i.row_upd) found_q <= 1'b1;
        unique case (cmd_i.j_op)
          stsu_pkg::CNT_CLR: j_q <= '0;
          stsu_pkg::CNT_INC: j_q <= j_q + 5'd1;
          default: ;
        endcase
      end
      unique case (cmd_i.i_op)
        stsu_pkg::CNT_CLR: i_q <= '0;
        stsu_pkg::CNT_INC: i_q <= i_q + 5'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      stsu_pkg::MUL_RATIO: begin mul_a = b_q; mul_b = ak_q; mul_c = bk_q; mul_d = a_q; end
      stsu_pkg::MUL_EXCH:  begin mul_a = a_q; mul_b = ak_q; mul_c = b_q;  mul_d = c_q; end
      stsu_pkg::MUL_SCALE: begin mul_a = a_q; mul_b = rcp_q; mul_c = '0;  mul_d = '0;  end
      default:             begin mul_a = a_q; mul_b = ak_q; mul_c = b_q;  mul_d = c_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_upd && rdata_q < 0 && (!need_q || rdata_q < best_q)) begin
      best_q <= rdata_q;
      pc_q   <= j_q;
    end
    if (cmd_i.row_upd && (!found_q || m1_q < m2_q)) begin
      pr_q <= i_q;
      ak_q <= a_q;
      bk_q <= b_q;
    end
    if (cmd_i.ld_a) a_q <= rdata_q;
    if (cmd_i.ld_b) b_q <= rdata_q;
    if (cmd_i.ld_c) c_q <= rdata_q;
    if (cmd_i.mul_en) begin
      m1_q <= 64'(mul_a) * 64'(mul_b);
      m2_q <= 64'(mul_c) * 64'(mul_d);
    end
    if (cmd_i.sub_en) diff_q <= m1_q - m2_q;
    if (cmd_i.mag_en) begin
      unique case (cmd_i.mag_sel)
        stsu_pkg::MAG_DIFF: begin
          neg_q <= diff_q < 0;
          mag_q <= (diff_q < 0) ? 64'(-diff_q) : 64'(diff_q);
        end
        stsu_pkg::MAG_ONE: begin
          neg_q <= 1'b0;
          mag_q <= 64'h1_0000_0000;
        end
        stsu_pkg::MAG_ROW: begin
          neg_q <= m1_q < 0;
          mag_q <= (m1_q < 0) ? 64'(-m1_q) : 64'(m1_q);
        end
        stsu_pkg::MAG_COL: begin
          neg_q <= m1_q > 0;
          mag_q <= (m1_q < 0) ? 64'(-m1_q) : 64'(m1_q);
        end
        default: ;
      endcase
    end
    if (cmd_i.rcp_load) rcp_q <= div_res;
    if (cmd_i.out_load) begin
      res_status_q <= cmd_i.out_status;
      res_opt_q    <= cmd_i.out_zero ? 32'sd0 : rdata_q;
      res_cnt_q    <= cnt_q;
    end
  end

  stsu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (mag_q + {33'd0, ak_q[31:1]}),
    .den_i   (ak_q),
    .neg_i   (neg_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    sts_o           = '0;
    sts_o.need_nx   = need_q || (rdata_q < 0);
    sts_o.rd_pos    = rdata_q > 0;
    sts_o.found     = found_q;
    sts_o.limit_hit = cnt_q >= limit_q;
    sts_o.i_eq_pr   = i_q == pr_q;
    sts_o.j_eq_pc   = j_q == pc_q;
    sts_o.i_is_m    = i_q == m_q;
    sts_o.i_is_m1   = i_q == 5'(m_q - 5'd1);
    sts_o.j_is_n    = j_q == n_q;
    sts_o.j_is_n1   = j_q == 5'(n_q - 5'd1);
    sts_o.div_done  = div_done;
  end

  assign out_status_o  = res_status_q;
  assign out_optimum_o = res_opt_q;
  assign out_pivots_o  = res_cnt_q;

endmodule

### hdl/simplex_tableau_solver_unit.sv
// Simplex tableau solver, top level: stream ports, configuration port,
// sequencer and datapath. Depends on stsu_pkg, stsu_ctrl, stsu_dpath.
//
// Configure rows_used, cols_used and iteration_limit over the cfg port while
// the unit is idle. Stream tableau words in on s_axis, one per cycle; row
// rows_used is the objective row, column cols_used the right-hand side.
// A word with tlast stores its entry and starts the solve; s_axis_tready
// stays low until the solve finishes. One result word (status, optimum,
// pivot count) then leaves on m_axis.
// Each pivot starts with a column search and a row search. Per pivot the
// reciprocal of the pivot is computed, then each of the m*n entries outside
// the pivot row and column is updated, paced by the one-bit-per-cycle
// divider and the single tableau memory port, and then each other entry of
// the pivot row and column is scaled.
// Reset clears the sequencer and loads default configuration; tableau
// contents are undefined until written. While m_axis stalls, the result is
// held and further non-final words are still accepted; a final word waits
// before its result is written until the previous one is taken.
module simplex_tableau_solver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // row[4:0], column[9:5], value[41:10]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // optimum[31:0], pivots_done[41:32]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  stsu_pkg::cmd_t     cmd;
  stsu_pkg::sts_t     sts;
  logic signed [31:0] optimum;
  logic [9:0]         pivots;

  assign cfg_ready_o = 1'b1;

  stsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  stsu_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_row_i      (s_axis_tdata[4:0]),
    .in_column_i   (s_axis_tdata[9:5]),
    .in_value_i    ($signed(s_axis_tdata[41:10])),
    .out_status_o  (m_axis_tuser),
    .out_optimum_o (optimum),
    .out_pivots_o  (pivots)
  );

  assign m_axis_tdata = {6'd0, pivots, optimum};

endmodule

### test/tb_simplex_tableau_solver_unit.sv
// Testbench for simplex_tableau_solver_unit: directed table, then random tableau frames,
// each result checked against a cycle-free simplex predictor. Depends on stsu_pkg and the RTL.
module tb_simplex_tableau_solver_unit;

  localparam int unsigned MaxRows = stsu_pkg::MaxRows;
  localparam int unsigned MaxCols = stsu_pkg::MaxCols;
  localparam int unsigned Stride  = stsu_pkg::Stride;
  localparam int unsigned Depth   = stsu_pkg::Depth;

  typedef enum logic {OP_CFG, OP_WORD} dir_op_e;

  typedef struct {
    dir_op_e     op;
    logic [1:0]  idx;
    logic [15:0] data;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [31:0] value;
    logic        last;
    logic        chk;
    logic [1:0]  status;
    logic [31:0] optimum;
    logic [9:0]  pivots;
  } dir_row_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] optimum;
    logic [9:0]  pivots;
  } solve_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [47:0] s_data;
  logic        s_last;
  logic        m_valid;
  logic        m_ready;
  logic [47:0] m_data;
  logic [1:0]  m_user;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  logic signed [31:0] tab_q [Depth];
  bit                 written_q [Depth];
  logic [4:0]         rows_reg;
  logic [4:0]         cols_reg;
  logic [9:0]         limit_reg;

  solve_res_t solve_q[$];
  int         errors_n;
  int         words_n;
  int         send_idle;
  int         recv_idle;

  simplex_tableau_solver_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  function automatic int used_rows();
    int m;
    m = rows_reg;
    if (m < 1) m = 1;
    if (m > MaxRows) m = MaxRows;
    return m;
  endfunction

  function automatic int used_cols();
    int n;
    n = cols_reg;
    if (n < 1) n = 1;
    if (n > MaxCols) n = MaxCols;
    return n;
  endfunction

  function automatic logic signed [31:0] sat_q(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] div_near(longint num, longint den);
    logic                neg;
    longint unsigned     mag;
    longint unsigned     q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag + den / 2) / den;
    if (q > 64'h7FFF_FFFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF_FFFF;
    return sat_q(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic solve_res_t solve_tableau();
    solve_res_t res;
    int         m, n, pr, pc;
    int unsigned cnt;
    logic signed [31:0] best;
    bit         need, found;
    longint     p, rcp, a, c, w;
    m = used_rows();
    n = used_cols();
    cnt = 0;
    forever begin
      need = 0; found = 0; pc = 0; pr = 0; best = 0;
      for (int j = 0; j < n; j++)
        if (tab_q[m*Stride+j] < 0 && (!need || tab_q[m*Stride+j] < best)) begin
          best = tab_q[m*Stride+j]; pc = j; need = 1;
        end
      if (!need) begin
        res.status = stsu_pkg::StatusOptimal; res.optimum = tab_q[m*Stride+n]; break;
      end
      for (int i = 0; i < m; i++) begin
        a = tab_q[i*Stride+pc];
        if (a > 0) begin
          if (!found) begin
            pr = i; found = 1;
          end else if (longint'(tab_q[i*Stride+n]) * tab_q[pr*Stride+pc] <
                       longint'(tab_q[pr*Stride+n]) * a) begin
            pr = i;
          end
        end
      end
      if (!found) begin
        res.status = stsu_pkg::StatusUnbounded; res.optimum = 0; break;
      end
      if (cnt >= limit_reg) begin
        res.status = stsu_pkg::StatusLimit; res.optimum = tab_q[m*Stride+n]; break;
      end
      p = tab_q[pr*Stride+pc];
      rcp = div_near(64'sd1 <<< 32, p);
      for (int i = 0; i <= m; i++) begin
        if (i == pr) continue;
        for (int j = 0; j <= n; j++) begin
          if (j == pc) continue;
          a = tab_q[i*Stride+j];
          c = tab_q[i*Stride+pc];
          w = tab_q[pr*Stride+j];
          tab_q[i*Stride+j] = div_near(a * p - c * w, p);
        end
      end
      for (int j = 0; j <= n; j++)
        if (j != pc) tab_q[pr*Stride+j] = div_near(tab_q[pr*Stride+j] * rcp, 65536);
      for (int i = 0; i <= m; i++)
        if (i != pr) tab_q[i*Stride+pc] = div_near(-(tab_q[i*Stride+pc] * rcp), 65536);
      tab_q[pr*Stride+pc] = rcp[31:0];
      cnt = (cnt + 1) & 10'h3FF;
    end
    res.pivots = cnt[9:0];
    return res;
  endfunction

  function automatic bit area_ready(int r, int c);
    int m, n;
    m = used_rows();
    n = used_cols();
    for (int i = 0; i <= m; i++)
      for (int j = 0; j <= n; j++)
        if (!written_q[i*Stride+j] && !(i == r && j == c)) return 0;
    return 1;
  endfunction

  task automatic send_word(logic [4:0] r, logic [4:0] c, logic [31:0] v, logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, v, c, r};
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    words_n++;
    if (r <= MaxRows && c <= MaxCols) begin
      tab_q[r*Stride+c] = v;
      written_q[r*Stride+c] = 1;
    end
    if (last) solve_q.push_back(solve_tableau());
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (solve_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      stsu_pkg::RegRowsUsed:  rows_reg = data[4:0];
      stsu_pkg::RegColsUsed:  cols_reg = data[4:0];
      stsu_pkg::RegIterLimit: limit_reg = data[9:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] entry_value(int r, int c, int m, int n);
    if ($urandom_range(0, 99) < 5) return $urandom();
    if (r == m && c == n) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65536) : 0;
    if (r == m) return ($urandom_range(0, 99) < 20) ? $urandom_range(0, 4 << 16)
                                                    : -$urandom_range(1, 8 << 16);
    if (c == n) return ($urandom_range(0, 99) < 10) ? -$urandom_range(1, 4 << 16)
                                                    : $urandom_range(0, 20 << 16);
    return ($urandom_range(0, 99) < 15) ? -$urandom_range(1, 4 << 16)
                                        : $urandom_range(0, 8 << 16);
  endfunction

  task automatic send_frame();
    int m, n, k, cut;
    bit lst;
    m = used_rows();
    n = used_cols();
    k = 0;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (m + 1) * (n + 1) - 1) : -1;
    for (int r = 0; r <= m; r++)
      for (int c = 0; c <= n; c++) begin
        if ($urandom_range(0, 99) < 5)
          send_word(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), $urandom(), 1'b0);
        lst = (r == m && c == n) || (k == cut && area_ready(r, c));
        send_word(5'(r), 5'(c), entry_value(r, c, m, n), lst);
        if (lst) return;
        k++;
      end
  endtask

  always @(posedge clk_i) m_ready <= ($urandom_range(0, 99) >= recv_idle);

  always @(posedge clk_i) begin
    solve_res_t e;
    if (m_valid && m_ready) begin
      if (solve_q.size() == 0) begin
        $error("result word with none expected");
        errors_n++;
      end else begin
        e = solve_q.pop_front();
        if (m_user !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_user);
          errors_n++;
        end
        if (m_data[31:0] !== e.optimum) begin
          $error("optimum: expected %h, got %h", e.optimum, m_data[31:0]);
          errors_n++;
        end
        if (m_data[41:32] !== e.pivots) begin
          $error("pivots_done: expected %0d, got %0d", e.pivots, m_data[41:32]);
          errors_n++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[$];
    int       p;
    dir_tab = '{
      '{OP_CFG, stsu_pkg::RegRowsUsed, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, stsu_pkg::RegColsUsed, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, stsu_pkg::RegIterLimit, 255, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 0, 1, 32'h0004_0000, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 1, 1, 32'h0000_0000, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 1, 0, 32'hFFFF_0000, 1, 1, stsu_pkg::StatusOptimal, 32'h0004_0000, 1},
      '{OP_WORD, 0, 0, 0, 0, 32'hFFFF_0000, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 1, 0, 32'hFFFF_0000, 1, 1, stsu_pkg::StatusUnbounded, 32'h0, 0},
      '{OP_WORD, 0, 0, 1, 0, 32'h7FFF_FFFF, 1, 1, stsu_pkg::StatusOptimal, 32'h0004_0000, 0},
      '{OP_CFG, stsu_pkg::RegIterLimit, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 1, 0, 32'hFFFF_0000, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 0, 0, 32'h0001_0000, 1, 1, stsu_pkg::StatusLimit, 32'h0004_0000, 0},
      '{OP_WORD, 0, 0, 31, 31, 32'hFFFF_FFFF, 1, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 16, 16, 32'h8000_0000, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 17, 0, 32'h1234_5678, 0, 0, 0, 0, 0},
      '{OP_CFG, stsu_pkg::RegIterLimit, 1023, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 0, 1, 32'h8000_0000, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 1, 0, 32'h8000_0000, 0, 0, 0, 0, 0},
      '{OP_WORD, 0, 0, 0, 0, 32'h0000_0001, 1, 0, 0, 0, 0}
    };
    errors_n = 0; words_n = 0;
    rows_reg = 1; cols_reg = 1; limit_reg = 255;
    foreach (tab_q[i]) begin
      tab_q[i] = 0; written_q[i] = 0;
    end
    send_idle = 22; recv_idle = 86;
    rst_ni = 1'b0; s_valid = 1'b0; s_data = '0; s_last = 1'b0;
    cfg_valid = 1'b0; cfg_index = stsu_pkg::RegRowsUsed; cfg_data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == OP_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_word(dir_tab[i].row, dir_tab[i].col, dir_tab[i].value, dir_tab[i].last);
        if (dir_tab[i].chk)
          solve_q[$] = '{dir_tab[i].status, dir_tab[i].optimum, dir_tab[i].pivots};
      end
    end

    p = 0;
    while (words_n < 1100) begin
      if (words_n >= 800) begin
        send_idle = 0; recv_idle = 0;
      end else if (words_n >= 400) begin
        send_idle = 86; recv_idle = 22;
      end
      case (p)
        0: begin write_reg(stsu_pkg::RegRowsUsed, 16'd31);
                 write_reg(stsu_pkg::RegColsUsed, 16'd0);
                 write_reg(stsu_pkg::RegIterLimit, 16'd1); end
        1: begin write_reg(stsu_pkg::RegRowsUsed, 16'd0);
                 write_reg(stsu_pkg::RegColsUsed, 16'd31);
                 write_reg(stsu_pkg::RegIterLimit, 16'd0); end
        2: begin write_reg(stsu_pkg::RegRowsUsed, 16'd16);
                 write_reg(stsu_pkg::RegColsUsed, 16'd2);
                 write_reg(stsu_pkg::RegIterLimit, 16'd3); end
        3: begin write_reg(stsu_pkg::RegRowsUsed, 16'd2);
                 write_reg(stsu_pkg::RegColsUsed, 16'd16);
                 write_reg(stsu_pkg::RegIterLimit, 16'd2); end
        4: begin write_reg(stsu_pkg::RegRowsUsed, 16'd1);
                 write_reg(stsu_pkg::RegColsUsed, 16'd1);
                 write_reg(stsu_pkg::RegIterLimit, 16'd1023); end
        default: begin
          write_reg(stsu_pkg::RegRowsUsed, 16'($urandom_range(1, 4)));
          write_reg(stsu_pkg::RegColsUsed, 16'($urandom_range(1, 4)));
          write_reg(stsu_pkg::RegIterLimit, 16'($urandom_range(1, 6)));
        end
      endcase
      begin
        int start_n;
        start_n = words_n;
        while (words_n - start_n < 60) send_frame();
      end
      p++;
    end

    s_valid <= 1'b0;
    while (solve_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors_n == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
